>>> rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger: measurement
// phases, controller states, register indexes and control/status bundles.
// ----------------------------------------------------------------------------
package uer_pkg;

    // distance result width and saturation value, 1/16 cm units
    localparam int unsigned DIST_W   = 15;
    localparam logic [DIST_W-1:0] DIST_MAX = 15'h7FFF;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_CM  = 2'd2;

    // register values after reset
    localparam logic [7:0]  RST_TRIGGER_TICKS = 8'd20;
    localparam logic [15:0] RST_GAP_TICKS     = 16'd50000;
    localparam logic [7:0]  RST_TICKS_PER_CM  = 8'd58;

    // phase of the measurement sequence
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TRIG = 3'd1,
        PH_WAIT = 3'd2,
        PH_MEAS = 3'd3,
        PH_GAP  = 3'd4
    } t_phase;

    // controller states
    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DIV  = 2'd1,
        ST_LOAD = 2'd2
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic step;       // apply one accepted tick to the sequence state
        logic load_step;  // load the output register with this tick's result
        logic div_start;  // launch the averaging divide
        logic load_done;  // load the output register with the done result
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic done_next;  // the tick on the inputs ends the sequence
        logic div_done;   // divide result ready
    } t_sts;

endpackage

>>> rtl/uer_div.sv
// ----------------------------------------------------------------------------
// uer_div
// Restoring unsigned divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module uer_div
    import uer_pkg::*;
#(
    parameter int unsigned DVD_W = 23,
    parameter int unsigned DVS_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quo
);

    localparam int unsigned CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;

    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    // trial subtraction of the shifted partial remainder
    assign w_shift = {r_rem, r_quo[DVD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> rtl/uer_dp.sv
// ----------------------------------------------------------------------------
// uer_dp
// Datapath: configuration registers, measurement sequence state, echo width
// accumulation, averaging divide and the registered result.
// ----------------------------------------------------------------------------
module uer_dp
    import uer_pkg::*;
#(
    parameter int unsigned SAMPLES   = 5,
    parameter int unsigned ECHO_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_start_req,
    input  logic                  i_echo,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_trigger,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic [DIST_W-1:0]     o_distance
);

    localparam int unsigned IDX_W = $clog2(SAMPLES + 1);
    localparam int unsigned SUM_W = ECHO_BITS + $clog2(SAMPLES);
    localparam int unsigned DVD_W = SUM_W + 4;
    localparam int unsigned DVS_W = 8 + $clog2(SAMPLES + 1);
    localparam int unsigned CMP_W = (DVD_W > DIST_W) ? DVD_W : DIST_W;
    localparam logic [ECHO_BITS-1:0] WIDTH_MAX = '1;

    // configuration registers
    logic [7:0]           r_trig_ticks;
    logic [15:0]          r_gap_ticks;
    logic [7:0]           r_tpc;

    // sequence state
    t_phase               r_phase,  n_phase;
    logic [15:0]          r_timer,  n_timer;
    logic [ECHO_BITS-1:0] r_width,  n_width;
    logic [IDX_W-1:0]     r_idx,    n_idx;
    logic [SUM_W-1:0]     r_sum,    n_sum;
    logic [DIST_W-1:0]    r_dist_hold;
    logic                 n_trig;
    logic                 n_done;

    // result register
    logic                 r_out_trig;
    logic                 r_out_busy;
    logic                 r_out_done;
    logic [DIST_W-1:0]    r_out_dist;

    // divider hookup
    logic [DVD_W-1:0]     w_dividend;
    logic [DVS_W-1:0]     w_divisor;
    logic [DVD_W-1:0]     w_quo;
    logic                 w_div_done;
    logic [CMP_W-1:0]     w_quo_x;
    logic [DIST_W-1:0]    w_dist_sat;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_ticks <= RST_TRIGGER_TICKS;
            r_gap_ticks  <= RST_GAP_TICKS;
            r_tpc        <= RST_TICKS_PER_CM;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRIGGER_TICKS: r_trig_ticks <= i_cfg_data[7:0];
                CFG_GAP_TICKS:     r_gap_ticks  <= i_cfg_data;
                CFG_TICKS_PER_CM:  r_tpc        <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // next sequence state for one tick
    always_comb begin
        t_phase               ph;
        logic [15:0]          tmr;
        logic [15:0]          tmr_inc;
        logic [IDX_W-1:0]     idx;
        logic [SUM_W-1:0]     sum;

        ph      = r_phase;
        tmr     = r_timer;
        idx     = r_idx;
        sum     = r_sum;
        // start request only counts when idle
        if (r_phase == PH_IDLE && i_start_req) begin
            ph  = PH_TRIG;
            tmr = '0;
            idx = '0;
            sum = '0;
        end
        tmr_inc = tmr + 16'd1;

        n_phase = ph;
        n_timer = tmr;
        n_width = r_width;
        n_idx   = idx;
        n_sum   = sum;
        n_trig  = 1'b0;
        n_done  = 1'b0;

        case (ph)
            PH_TRIG: begin
                n_trig = 1'b1;
                if (tmr_inc >= {8'd0, r_trig_ticks}) begin
                    n_phase = PH_WAIT;
                    n_timer = '0;
                end else begin
                    n_timer = tmr_inc;
                end
            end
            PH_WAIT: begin
                if (i_echo) begin
                    n_width = ECHO_BITS'(1);
                    n_phase = PH_MEAS;
                end
            end
            PH_MEAS: begin
                if (i_echo) begin
                    if (r_width != WIDTH_MAX) begin
                        n_width = r_width + 1'b1;
                    end
                end else begin
                    n_sum   = sum + SUM_W'(r_width);
                    n_idx   = idx + 1'b1;
                    n_phase = PH_GAP;
                    n_timer = '0;
                end
            end
            PH_GAP: begin
                // timer saturates at the gap length
                if (tmr < r_gap_ticks) begin
                    n_timer = tmr_inc;
                end
                if (n_timer >= r_gap_ticks) begin
                    n_timer = '0;
                    if (idx >= IDX_W'(SAMPLES)) begin
                        n_done  = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_TRIG;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // sequence state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_width <= '0;
            r_idx   <= '0;
            r_sum   <= '0;
        end else if (i_cmd.step) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_width <= n_width;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
        end
    end

    // averaging divide: 16 * sum / (ticks_per_cm * samples)
    assign w_dividend = {r_sum, 4'b0000};
    assign w_divisor  = DVS_W'(r_tpc) * DVS_W'(SAMPLES);

    uer_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quo      (w_quo)
    );

    // saturation, including the zero divisor case
    assign w_quo_x    = CMP_W'(w_quo);
    assign w_dist_sat = (r_tpc == 8'd0 || w_quo_x > CMP_W'(DIST_MAX))
                      ? DIST_MAX : w_quo_x[DIST_W-1:0];

    // held distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_hold <= '0;
        end else if (i_cmd.load_done) begin
            r_dist_hold <= w_dist_sat;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_done) begin
            r_out_trig <= 1'b0;
            r_out_busy <= 1'b0;
            r_out_done <= 1'b1;
            r_out_dist <= w_dist_sat;
        end else if (i_cmd.load_step) begin
            r_out_trig <= n_trig;
            r_out_busy <= (n_phase != PH_IDLE);
            r_out_done <= 1'b0;
            r_out_dist <= r_dist_hold;
        end
    end

    assign o_sts.done_next = n_done;
    assign o_sts.div_done  = w_div_done;

    assign o_trigger  = r_out_trig;
    assign o_busy_res = r_out_busy;
    assign o_done_res = r_out_done;
    assign o_distance = r_out_dist;

    // a finishing tick leaves the sequence idle
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> (r_phase == PH_IDLE))
        else $error("sequence not idle after the final gap");

    // held distance changes only with the done result
    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.load_done |=> $stable(r_dist_hold))
        else $error("held distance changed without a done result");

    // trigger level only reported inside a running sequence
    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_step && n_trig) |-> (n_phase != PH_IDLE))
        else $error("trigger reported while idle");

endmodule

>>> rtl/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl
// Controller: input and output handshakes, output register occupancy and
// sequencing of the averaging divide on the final tick.
// ----------------------------------------------------------------------------
module uer_ctrl
    import uer_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_accept;

    // output slot is free when empty or being taken this cycle
    assign w_out_free = !r_out_valid || !i_stall;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        w_accept = 1'b0;
        o_stall  = 1'b1;

        case (r_state)
            ST_RUN: begin
                o_stall  = !w_out_free;
                w_accept = i_valid && w_out_free;
                if (w_accept) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.done_next) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = ST_DIV;
                    end else begin
                        o_cmd.load_step = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (w_out_free) begin
                    o_cmd.load_done = 1'b1;
                    n_state         = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase

        // output register occupancy
        if (o_cmd.load_step || o_cmd.load_done) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    // divide only launched by an accepted tick
    a_div_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> (o_cmd.step && !o_cmd.load_step))
        else $error("divide launched without a transfer");

    // no tick taken while the divide runs
    a_no_step_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> !o_cmd.step)
        else $error("tick taken during the divide");

    // a result appears only after a load
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_cmd.load_step || o_cmd.load_done))
        else $error("result valid without a load");

endmodule

>>> rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Pulse-echo ranging sequencer: trigger, echo width count, averaging divide.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_valid / o_stall): one transfer per microsecond tick with
//   the start request and the sampled echo level. Output channel (o_valid /
//   i_stall): exactly one result transfer per input tick, in order, carrying
//   trigger level, busy, done pulse and the held distance in 1/16 cm.
//   Config channel (i_cfg_valid / o_cfg_ready): index 0 trigger width,
//   1 gap length, 2 ticks per cm; ready is always high, writes act at once.
//   A taken tick's result is loaded into the result register, so ordinary
//   ticks run at one per cycle while the receiver does not stall. The tick
//   that ends the last gap starts a restoring divide instead; its result
//   passes through the ST_DIV and ST_LOAD states into the result register,
//   and no tick is taken while the divide runs.
//   Reset loads the default register values, idles the sequence and clears
//   the held distance. A stalled receiver holds the result register; a new
//   tick is taken only when that register is empty or being drained.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int unsigned SAMPLES   = 5,
    parameter int unsigned ECHO_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input tick channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_start_req,
    input  logic                  i_echo,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_trigger,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic [DIST_W-1:0]     o_distance,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // configuration always taken
    assign o_cfg_ready = 1'b1;

    // controller
    uer_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // datapath
    uer_dp #(
        .SAMPLES   (SAMPLES),
        .ECHO_BITS (ECHO_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_start_req (i_start_req),
        .i_echo      (i_echo),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_trigger   (o_trigger),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_distance  (o_distance)
    );

endmodule
